FILE: rtl/dqc_pkg.sv
// shared types and command codes for the deque checker
package dqc_pkg;

    localparam int FIELD_W = 32;
    localparam int OCC_W   = 11;

    // command codes
    localparam logic [1:0] FUNC_ADD_FRONT  = 2'd0;
    localparam logic [1:0] FUNC_TAKE_FRONT = 2'd1;
    localparam logic [1:0] FUNC_ADD_BACK   = 2'd2;
    localparam logic [1:0] FUNC_TAKE_BACK  = 2'd3;

    typedef struct packed {
        logic [1:0]         func;
        logic [FIELD_W-1:0] value;
    } cmd_t;

    typedef struct packed {
        logic [FIELD_W-1:0] popped_value;
        logic               mismatch_now;
        logic               failed;
        logic               push_dropped;
        logic [OCC_W-1:0]   occupancy;
    } rsp_t;

    // command held between the pointer stage and the check stage
    typedef struct packed {
        logic               pop;
        logic               empty;
        logic               dropped;
        logic [FIELD_W-1:0] expect_value;
        logic [OCC_W-1:0]   occupancy;
    } pend_t;

endpackage

FILE: rtl/dqc_ram.sv
// generic single-port-write, single-port-read ram with registered read
module dqc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/dqc_ctrl.sv
// pointer and count stage: accepts commands and issues store accesses
module dqc_ctrl
    import dqc_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    output logic                     cmd_stall,
    input  cmd_t                     cmd,
    input  logic                     pend_take,
    output logic                     pend_valid,
    output pend_t                    pend,
    output logic                     mem_we,
    output logic [$clog2(DEPTH)-1:0] mem_waddr,
    output logic [DATA_WIDTH-1:0]    mem_wdata,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_raddr
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [PW-1:0] front_reg, front_next;
    logic [PW-1:0] back_reg, back_next;
    logic [CW-1:0] count_reg, count_next;
    logic          pend_valid_reg, pend_valid_next;
    pend_t         pend_reg, pend_next;

    logic          accept;
    logic          full;
    logic          empty;
    logic [PW-1:0] front_inc, front_dec, back_inc, back_dec;
    logic [63:0]   value_ext;
    logic [CW+OCC_W-1:0] occ_ext;

    // handshake: hold off while the pending command cannot move on
    assign cmd_stall = pend_valid_reg && !pend_take;
    assign accept    = cmd_valid && !cmd_stall;

    assign full  = (count_reg == CNT_FULL);
    assign empty = (count_reg == '0);

    // ring neighbors of both pointers
    assign front_inc = (front_reg == PTR_LAST) ? '0 : front_reg + 1'b1;
    assign front_dec = (front_reg == '0) ? PTR_LAST : front_reg - 1'b1;
    assign back_inc  = (back_reg == PTR_LAST) ? '0 : back_reg + 1'b1;
    assign back_dec  = (back_reg == '0) ? PTR_LAST : back_reg - 1'b1;

    // only the low data bits are kept
    assign value_ext = {32'b0, cmd.value};
    assign mem_wdata = value_ext[DATA_WIDTH-1:0];

    // pointer, count and store access for the accepted beat
    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        count_next = count_reg;
        mem_we     = 1'b0;
        mem_waddr  = front_reg;
        mem_re     = 1'b0;
        mem_raddr  = front_inc;
        if (accept)
        begin
            unique case (cmd.func)
                FUNC_ADD_FRONT:
                begin
                    mem_waddr = front_reg;
                    if (!full)
                    begin
                        mem_we     = 1'b1;
                        front_next = front_dec;
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_ADD_BACK:
                begin
                    mem_waddr = back_reg;
                    if (!full)
                    begin
                        mem_we     = 1'b1;
                        back_next  = back_inc;
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_TAKE_FRONT:
                begin
                    mem_raddr = front_inc;
                    if (!empty)
                    begin
                        mem_re     = 1'b1;
                        front_next = front_inc;
                        count_next = count_reg - 1'b1;
                    end
                end
                FUNC_TAKE_BACK:
                begin
                    mem_raddr = back_dec;
                    if (!empty)
                    begin
                        mem_re     = 1'b1;
                        back_next  = back_dec;
                        count_next = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    mem_we = 1'b0;
                end
            endcase
            // drained queue sends both pointers home
            if (cmd.func[0] && count_reg == CW'(1))
            begin
                front_next = PTR_LAST;
                back_next  = '0;
            end
        end
    end

    // pending command for the check stage
    assign occ_ext = {{OCC_W{1'b0}}, count_next};

    always_comb
    begin
        pend_next              = pend_reg;
        pend_next.pop          = cmd.func[0];
        pend_next.empty        = empty;
        pend_next.dropped      = !cmd.func[0] && full;
        pend_next.expect_value = cmd.value;
        pend_next.occupancy    = occ_ext[OCC_W-1:0];
    end

    always_comb
    begin
        if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_take)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= PTR_LAST;
            back_reg       <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            back_reg       <= back_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // pending payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_reg <= pend_next;
        end
    end

    assign pend_valid = pend_valid_reg;
    assign pend       = pend_reg;

endmodule

FILE: rtl/dqc_check.sv
// check stage: compares popped data, keeps the failure flag, holds the result beat
module dqc_check
    import dqc_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  pend_valid,
    input  pend_t                 pend,
    input  logic [DATA_WIDTH-1:0] rdata,
    output logic                  pend_take,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output rsp_t                  rsp
);

    logic                    rsp_valid_reg, rsp_valid_next;
    rsp_t                    rsp_reg, rsp_next;
    logic                    fail_reg, fail_next;
    logic                    load;
    logic [DATA_WIDTH-1:0]   popped;
    logic [63:0]             expect_ext;
    logic [DATA_WIDTH+63:0]  popped_ext;
    logic                    mism;

    // result register frees up when empty or being taken
    assign pend_take = !rsp_valid_reg || !rsp_stall;
    assign load      = pend_valid && pend_take;

    // popped element, all ones for an empty pop
    assign popped     = pend.empty ? '1 : rdata;
    assign expect_ext = {32'b0, pend.expect_value};
    assign mism       = pend.pop && (popped != expect_ext[DATA_WIDTH-1:0]);
    assign popped_ext = {64'b0, popped};
    assign fail_next  = fail_reg || mism;

    // result beat
    always_comb
    begin
        rsp_next.popped_value = pend.pop ? popped_ext[FIELD_W-1:0] : '0;
        rsp_next.mismatch_now = mism;
        rsp_next.failed       = fail_next;
        rsp_next.push_dropped = pend.dropped;
        rsp_next.occupancy    = pend.occupancy;
    end

    always_comb
    begin
        if (pend_take)
        begin
            rsp_valid_next = pend_valid;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control state and sticky failure
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            fail_reg      <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (load)
            begin
                fail_reg <= fail_next;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

FILE: rtl/deque_checker.sv
// deque checker top level: pointer stage, element store and check stage
//
// A double-ended queue of up to DEPTH elements kept in one synchronous ram,
// used to check a stream of push and pop commands. A command beat is taken
// every cycle as long as the result side keeps up; each beat gives exactly
// one result beat, offered from the result register after passing the
// pending register. The pointer stage updates the front and back pointers
// and the count in the accept cycle and issues a single store write (push)
// or read (pop); the popped element comes out of the ram's registered read
// port and is compared in the check stage, which also holds the result
// register. While a result waits, one more command is held and then the
// input stalls. A pop on an empty queue returns all ones, a push on a full
// queue is dropped and flagged. The store needs no clearing after reset:
// only written entries are ever read.
module deque_checker
    import dqc_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int DATA_WIDTH = 32
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic rsp_valid,
    input  logic rsp_stall,
    output rsp_t rsp
);

    localparam int PW = $clog2(DEPTH);

    logic                  pend_take;
    logic                  pend_valid;
    pend_t                 pend;
    logic                  mem_we;
    logic [PW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic                  mem_re;
    logic [PW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // pointers and count
    dqc_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd_valid  (cmd_valid),
        .cmd_stall  (cmd_stall),
        .cmd        (cmd),
        .pend_take  (pend_take),
        .pend_valid (pend_valid),
        .pend       (pend),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_re     (mem_re),
        .mem_raddr  (mem_raddr)
    );

    // element store
    dqc_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // compare and result register
    dqc_check #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .pend_valid (pend_valid),
        .pend       (pend),
        .rdata      (mem_rdata),
        .pend_take  (pend_take),
        .rsp_valid  (rsp_valid),
        .rsp_stall  (rsp_stall),
        .rsp        (rsp)
    );

endmodule

FILE: verif/tb_top.sv
// self-checking testbench for the deque checker: directed and random push/pop beats
`timescale 1ns / 1ps

module tb_top;
    import dqc_pkg::*;

    localparam int DEPTH      = 1024;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int HALF_CLK   = 2;
    localparam int HOLD_LEN   = 200;
    localparam int STUCK_MAX  = 2000;
    localparam int SHOW_MAX   = 10;

    // idling modes carried by each planned beat
    localparam int IDLE_NONE  = 0;
    localparam int IDLE_SEND  = 1;
    localparam int IDLE_RECV  = 2;
    localparam int IDLE_BOTH  = 3;
    localparam int IDLE_PRESS = 4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    deque_checker #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (FIELD_W)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // clock
    initial
    begin
        forever #HALF_CLK clk = ~clk;
    end

    // planned command beats and their idling mode
    cmd_t               pend_q[$];
    int                 pend_mode_q[$];
    logic [FIELD_W-1:0] shadow_q[$];

    // ring model of the deque
    logic [FIELD_W-1:0] ring_mem [DEPTH];
    logic [PTR_W-1:0]   front_ptr = '1;
    logic [PTR_W-1:0]   back_ptr = '0;
    logic [OCC_W-1:0]   elem_cnt = '0;
    logic               sticky_fail = 1'b0;
    rsp_t               want_q[$];

    // run statistics
    int n_cmds = 0;
    int n_pushes = 0;
    int n_dropped = 0;
    int n_pops = 0;
    int n_empty_pops = 0;
    int n_mism_pops = 0;
    int peak_occ = 0;
    int n_rsp = 0;
    int errors = 0;

    logic cmd_fire = 1'b0;
    int   cur_mode = IDLE_NONE;
    int   hold_left = 0;
    bit   held_once = 1'b0;
    int   stuck_cycles = 0;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int idle_pct(int mode, bit recv_side);
        case (mode)
            IDLE_SEND: return recv_side ? 0 : 68;
            IDLE_RECV: return recv_side ? 68 : 0;
            IDLE_BOTH: return 24;
            default:   return 0;
        endcase
    endfunction

    function automatic logic [FIELD_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // plan a push and track what the deque will hold
    task automatic plan_push(bit at_front, logic [FIELD_W-1:0] v, int mode);
        cmd_t c;
        c.func  = at_front ? FUNC_ADD_FRONT : FUNC_ADD_BACK;
        c.value = v;
        pend_q.insert(pend_q.size(), c);
        pend_mode_q.insert(pend_mode_q.size(), mode);
        if (shadow_q.size() < DEPTH)
        begin
            if (at_front)
                shadow_q.insert(0, v);
            else
                shadow_q.insert(shadow_q.size(), v);
        end
    endtask

    // plan a pop; an honest pop expects the element that will come out
    task automatic plan_pop(bit at_front, bit honest, int mode);
        cmd_t               c;
        logic [FIELD_W-1:0] v;
        logic [FIELD_W-1:0] flip;
        if (shadow_q.size() == 0)
            v = '1;
        else if (at_front)
        begin
            v = shadow_q[0];
            shadow_q.delete(0);
        end
        else
        begin
            v = shadow_q[shadow_q.size() - 1];
            shadow_q.delete(shadow_q.size() - 1);
        end
        if (!honest)
        begin
            flip = $urandom;
            if (flip == '0)
                flip = 32'h0000_0001;
            v = v ^ flip;
        end
        c.func  = at_front ? FUNC_TAKE_FRONT : FUNC_TAKE_BACK;
        c.value = v;
        pend_q.insert(pend_q.size(), c);
        pend_mode_q.insert(pend_mode_q.size(), mode);
    endtask

    task automatic plan_random(int push_pct, int mode);
        if (chance(push_pct))
            plan_push($urandom_range(1), pick_value(), mode);
        else
            plan_pop($urandom_range(1), chance(92), mode);
    endtask

    // ring model step: update the state and return the expected result
    function automatic rsp_t deque_apply(cmd_t c);
        rsp_t r;
        r = '0;
        n_cmds++;
        if (c.func == FUNC_ADD_FRONT || c.func == FUNC_ADD_BACK)
        begin
            n_pushes++;
            if (elem_cnt >= DEPTH)
            begin
                r.push_dropped = 1'b1;
                n_dropped++;
            end
            else if (c.func == FUNC_ADD_FRONT)
            begin
                ring_mem[front_ptr] = c.value;
                front_ptr = front_ptr - 1'b1;
                elem_cnt = elem_cnt + 1'b1;
            end
            else
            begin
                ring_mem[back_ptr] = c.value;
                back_ptr = back_ptr + 1'b1;
                elem_cnt = elem_cnt + 1'b1;
            end
        end
        else
        begin
            n_pops++;
            if (elem_cnt == 0)
            begin
                r.popped_value = '1;
                n_empty_pops++;
            end
            else
            begin
                if (c.func == FUNC_TAKE_FRONT)
                begin
                    front_ptr = front_ptr + 1'b1;
                    r.popped_value = ring_mem[front_ptr];
                end
                else
                begin
                    back_ptr = back_ptr - 1'b1;
                    r.popped_value = ring_mem[back_ptr];
                end
                elem_cnt = elem_cnt - 1'b1;
                // drained queue sends both pointers home
                if (elem_cnt == 0)
                begin
                    front_ptr = '1;
                    back_ptr  = '0;
                end
            end
            r.mismatch_now = (r.popped_value != c.value);
            if (r.mismatch_now)
            begin
                sticky_fail = 1'b1;
                n_mism_pops++;
            end
        end
        r.failed    = sticky_fail;
        r.occupancy = elem_cnt;
        if (elem_cnt > peak_occ)
            peak_occ = elem_cnt;
        return r;
    endfunction

    // command driver
    always @(negedge clk)
    begin
        if (rst_n && (!cmd_valid || cmd_fire))
        begin
            if (pend_q.size() > 0 && !chance(idle_pct(pend_mode_q[0], 1'b0)))
            begin
                cmd       <= pend_q[0];
                cur_mode  <= pend_mode_q[0];
                cmd_valid <= 1'b1;
                pend_q.delete(0);
                pend_mode_q.delete(0);
            end
            else
                cmd_valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                rsp_stall <= 1'b1;
                hold_left <= hold_left - 1;
            end
            else if (!held_once && cur_mode == IDLE_PRESS)
            begin
                rsp_stall <= 1'b1;
                hold_left <= HOLD_LEN;
                held_once <= 1'b1;
            end
            else
                rsp_stall <= chance(idle_pct(cur_mode, 1'b1));
        end
    end

    // monitor: predict on accepted commands, check accepted results
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            cmd_fire <= cmd_valid && !cmd_stall;
            if (rsp_valid && !rsp_stall)
            begin
                n_rsp++;
                if (want_q.size() == 0)
                begin
                    errors++;
                    if (errors <= SHOW_MAX)
                        $display("result beat %0d arrived with nothing expected: %h",
                                 n_rsp, rsp);
                end
                else
                begin
                    want = want_q[0];
                    want_q.delete(0);
                    if (rsp !== want)
                    begin
                        errors++;
                        if (errors <= SHOW_MAX)
                        begin
                            $display("result beat %0d: want val=%h mis=%b fail=%b drop=%b occ=%0d",
                                     n_rsp, want.popped_value, want.mismatch_now,
                                     want.failed, want.push_dropped, want.occupancy);
                            $display("    got val=%h mis=%b fail=%b drop=%b occ=%0d",
                                     rsp.popped_value, rsp.mismatch_now, rsp.failed,
                                     rsp.push_dropped, rsp.occupancy);
                        end
                    end
                end
            end
            if (cmd_valid && !cmd_stall)
            begin
                want = deque_apply(cmd);
                want_q.insert(want_q.size(), want);
            end
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_MAX)
            begin
                $display("no beat for %0d cycles, %0d results outstanding",
                         stuck_cycles, want_q.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // stimulus plan, reset and end of run
    initial
    begin
        int mode;

        // directed: empty pops, both ends, cross-end traffic, drains
        plan_pop(1'b1, 1'b1, IDLE_NONE);
        plan_pop(1'b0, 1'b1, IDLE_NONE);
        plan_push(1'b1, 32'h0000_0000, IDLE_NONE);
        plan_push(1'b0, 32'hffff_ffff, IDLE_NONE);
        plan_push(1'b1, 32'ha5a5_a5a5, IDLE_NONE);
        plan_push(1'b0, 32'h5a5a_5a5a, IDLE_NONE);
        plan_pop(1'b1, 1'b1, IDLE_NONE);
        plan_pop(1'b0, 1'b1, IDLE_NONE);
        plan_pop(1'b1, 1'b1, IDLE_NONE);
        plan_pop(1'b0, 1'b1, IDLE_NONE);
        plan_push(1'b0, 32'h0000_0001, IDLE_NONE);
        plan_push(1'b0, 32'h0000_0002, IDLE_NONE);
        plan_pop(1'b1, 1'b1, IDLE_NONE);
        plan_pop(1'b1, 1'b1, IDLE_NONE);
        plan_push(1'b1, 32'h0000_0003, IDLE_NONE);
        plan_push(1'b1, 32'h0000_0004, IDLE_NONE);
        plan_pop(1'b0, 1'b1, IDLE_NONE);
        plan_pop(1'b0, 1'b1, IDLE_NONE);
        // wrong expectations, on a filled and on an empty queue
        plan_push(1'b1, 32'h8000_0000, IDLE_NONE);
        plan_pop(1'b1, 1'b0, IDLE_NONE);
        plan_pop(1'b0, 1'b0, IDLE_NONE);
        plan_push(1'b0, 32'h7fff_ffff, IDLE_NONE);
        plan_pop(1'b0, 1'b1, IDLE_NONE);

        // mixed traffic under each idling mode
        for (int b = 0; b < 6; b++)
            for (int i = 0; i < 25; i++)
                plan_random(55, b % 4);
        for (int i = 0; i < 40; i++)
            plan_random(55, IDLE_PRESS);

        // fill to full, then push into the full queue
        while (shadow_q.size() < DEPTH)
        begin
            mode = (pend_q.size() / 97) % 4;
            plan_random(97, mode);
        end
        for (int i = 0; i < 30; i++)
            plan_random(60, i % 4);

        // work the full queue back down, then mix again
        for (int i = 0; i < 150; i++)
        begin
            mode = (pend_q.size() / 89) % 4;
            plan_random(3, mode);
        end
        for (int i = 0; i < 40; i++)
            plan_random(40, i % 4);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pend_q.size() != 0 || cmd_valid || want_q.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d commands: %0d pushes (%0d dropped on a full queue), %0d pops",
                 n_cmds, n_pushes, n_dropped, n_pops);
        $display("%0d pops on an empty queue, %0d flagged pops, peak occupancy %0d of %0d",
                 n_empty_pops, n_mism_pops, peak_occ, DEPTH);
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/dqc_pkg.sv
rtl/dqc_ram.sv
rtl/dqc_ctrl.sv
rtl/dqc_check.sv
rtl/deque_checker.sv
verif/tb_top.sv
